>>> rtl/usc_pkg.sv
// usc_pkg: shared types, constants and the month table for the
// seconds-to-calendar pipeline; no dependencies
package usc_pkg;

    // pipeline depth, one valid bit per stage
    localparam int Stages = 10;
    localparam int LastStage = Stages - 1;

    typedef logic [Stages-1:0] t_stage_vec;

    // reciprocal multipliers, floor(2^k / divisor), with k >= dividend width
    localparam logic [26:0] Div60Mul32   = 27'd71582788;
    localparam logic [21:0] Div60Mul27   = 22'd2236962;
    localparam logic [16:0] Div24Mul21   = 17'd87381;
    localparam logic [5:0]  Div1461Mul16 = 6'd44;

    // calendar constants, days counted from 1968-03-01 in four-year cycles
    localparam logic [15:0] DayOffset    = 16'd671;    // 1968-03-01 to 1970-01-01
    localparam logic [15:0] Mar2100Day   = 16'd47541;  // 1970-01-01 to 2100-03-01
    localparam logic [15:0] DaysPerCycle = 16'd1461;
    localparam logic [10:0] DaysPerYear  = 11'd365;
    localparam logic [11:0] CycleBaseYear = 12'd1968;

    // march-based month index of january
    localparam logic [3:0] MarchBasedJan = 4'd10;

    // time of day plus whole days, handed from the clock part to the date part
    typedef struct packed {
        logic [15:0] days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_tod;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_result;

    // first day of each month within a year that starts on march 1
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] start;
        case (idx)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

>>> rtl/usc_if.sv
// usc_if: valid/ready channels for the seconds input and the calendar result
// depends on nothing
interface usc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface usc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [11:0] calendar_year;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;

    modport source (output valid, output second_of_minute, output minute_of_hour,
                    output hour_of_day, output calendar_year, output month_number,
                    output day_of_month, input ready);
    modport sink (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input calendar_year, input month_number,
                  input day_of_month, output ready);
endinterface

>>> rtl/usc_tod.sv
// usc_tod: stages 0 to 5, splits seconds into second, minute, hour and days
// depends on usc_pkg
module usc_tod (
    input  logic                i_clk,
    input  usc_pkg::t_stage_vec i_stage_en,
    input  logic [31:0]         i_epoch_seconds,
    output usc_pkg::t_tod       o_tod
);

    logic [31:0] r_s0_secs;
    logic [26:0] r_s0_quot, n_s0_quot;
    logic [26:0] r_s1_quot, n_s1_quot;
    logic [5:0]  r_s1_sec, n_s1_sec;
    logic [26:0] r_s2_mins;
    logic [20:0] r_s2_quot, n_s2_quot;
    logic [5:0]  r_s2_sec;
    logic [20:0] r_s3_hours, n_s3_hours;
    logic [5:0]  r_s3_min, n_s3_min;
    logic [5:0]  r_s3_sec;
    logic [20:0] r_s4_hours;
    logic [15:0] r_s4_quot, n_s4_quot;
    logic [5:0]  r_s4_min;
    logic [5:0]  r_s4_sec;
    logic [15:0] r_s5_days, n_s5_days;
    logic [4:0]  r_s5_hour, n_s5_hour;
    logic [5:0]  r_s5_min;
    logic [5:0]  r_s5_sec;

    logic [58:0] w_prod0;
    logic [31:0] w_q60_s1;
    logic [31:0] w_rem_s1;
    logic [48:0] w_prod2;
    logic [26:0] w_q60_s3;
    logic [26:0] w_rem_s3;
    logic [37:0] w_prod4;
    logic [20:0] w_q24_s5;
    logic [20:0] w_rem_s5;

    // stage 0: estimate seconds / 60 by reciprocal multiply
    assign w_prod0   = 59'(i_epoch_seconds) * 59'(usc_pkg::Div60Mul32);
    assign n_s0_quot = w_prod0[58:32];

    // stage 1: remainder and one-step correction give minutes and seconds
    always_comb begin
        w_q60_s1 = 32'({r_s0_quot, 6'b0}) - 32'({r_s0_quot, 2'b0});
        w_rem_s1 = r_s0_secs - w_q60_s1;
        if (w_rem_s1[6:0] >= 7'd60) begin
            n_s1_quot = r_s0_quot + 27'd1;
            n_s1_sec  = 6'(w_rem_s1[6:0] - 7'd60);
        end else begin
            n_s1_quot = r_s0_quot;
            n_s1_sec  = w_rem_s1[5:0];
        end
    end

    // stage 2: estimate minutes / 60
    assign w_prod2   = 49'(r_s1_quot) * 49'(usc_pkg::Div60Mul27);
    assign n_s2_quot = w_prod2[47:27];

    // stage 3: correction gives hours and minute of hour
    always_comb begin
        w_q60_s3 = 27'({r_s2_quot, 6'b0}) - 27'({r_s2_quot, 2'b0});
        w_rem_s3 = r_s2_mins - w_q60_s3;
        if (w_rem_s3[6:0] >= 7'd60) begin
            n_s3_hours = r_s2_quot + 21'd1;
            n_s3_min   = 6'(w_rem_s3[6:0] - 7'd60);
        end else begin
            n_s3_hours = r_s2_quot;
            n_s3_min   = w_rem_s3[5:0];
        end
    end

    // stage 4: estimate hours / 24
    assign w_prod4   = 38'(r_s3_hours) * 38'(usc_pkg::Div24Mul21);
    assign n_s4_quot = w_prod4[36:21];

    // stage 5: correction gives whole days and hour of day
    always_comb begin
        w_q24_s5 = 21'({r_s4_quot, 4'b0}) + 21'({r_s4_quot, 3'b0});
        w_rem_s5 = r_s4_hours - w_q24_s5;
        if (w_rem_s5[5:0] >= 6'd24) begin
            n_s5_days = r_s4_quot + 16'd1;
            n_s5_hour = 5'(w_rem_s5[5:0] - 6'd24);
        end else begin
            n_s5_days = r_s4_quot;
            n_s5_hour = w_rem_s5[4:0];
        end
    end

    // stage registers, each loads when its stage moves
    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_s0_secs <= i_epoch_seconds;
            r_s0_quot <= n_s0_quot;
        end
        if (i_stage_en[1]) begin
            r_s1_quot <= n_s1_quot;
            r_s1_sec  <= n_s1_sec;
        end
        if (i_stage_en[2]) begin
            r_s2_mins <= r_s1_quot;
            r_s2_quot <= n_s2_quot;
            r_s2_sec  <= r_s1_sec;
        end
        if (i_stage_en[3]) begin
            r_s3_hours <= n_s3_hours;
            r_s3_min   <= n_s3_min;
            r_s3_sec   <= r_s2_sec;
        end
        if (i_stage_en[4]) begin
            r_s4_hours <= r_s3_hours;
            r_s4_quot  <= n_s4_quot;
            r_s4_min   <= r_s3_min;
            r_s4_sec   <= r_s3_sec;
        end
        if (i_stage_en[5]) begin
            r_s5_days <= n_s5_days;
            r_s5_hour <= n_s5_hour;
            r_s5_min  <= r_s4_min;
            r_s5_sec  <= r_s4_sec;
        end
    end

    assign o_tod.days   = r_s5_days;
    assign o_tod.hour   = r_s5_hour;
    assign o_tod.minute = r_s5_min;
    assign o_tod.second = r_s5_sec;

endmodule

>>> rtl/usc_date.sv
// usc_date: stages 6 to 9, turns whole days into year, month and day
// depends on usc_pkg
module usc_date (
    input  logic                i_clk,
    input  usc_pkg::t_stage_vec i_stage_en,
    input  usc_pkg::t_tod       i_tod,
    output usc_pkg::t_result    o_result
);

    logic [15:0] r_s6_dp, n_s6_dp;
    logic [5:0]  r_s6_cyc, n_s6_cyc;
    logic [16:0] r_s6_time;
    logic [5:0]  r_s7_cyc, n_s7_cyc;
    logic [10:0] r_s7_rem, n_s7_rem;
    logic [16:0] r_s7_time;
    logic [11:0] r_s8_year, n_s8_year;
    logic [8:0]  r_s8_doy, n_s8_doy;
    logic [16:0] r_s8_time;
    logic [11:0] r_s9_year, n_s9_year;
    logic [3:0]  r_s9_month, n_s9_month;
    logic [4:0]  r_s9_day, n_s9_day;
    logic [16:0] r_s9_time;

    logic [21:0] w_prod6;
    logic [15:0] w_cyc_days;
    logic [15:0] w_rem_s7;
    logic [1:0]  w_yoff;
    logic [3:0]  w_mp;

    // stage 6: shift to a march 1968 origin, skip the missing leap day of 2100,
    // then estimate the four-year cycle
    always_comb begin
        n_s6_dp = i_tod.days + usc_pkg::DayOffset
                + 16'(i_tod.days >= usc_pkg::Mar2100Day);
        w_prod6  = 22'(n_s6_dp) * 22'(usc_pkg::Div1461Mul16);
        n_s6_cyc = w_prod6[21:16];
    end

    // stage 7: correction gives cycle and day within cycle
    always_comb begin
        w_cyc_days = 16'(r_s6_cyc) * usc_pkg::DaysPerCycle;
        w_rem_s7   = r_s6_dp - w_cyc_days;
        if (w_rem_s7[11:0] >= 12'(usc_pkg::DaysPerCycle)) begin
            n_s7_cyc = r_s6_cyc + 6'd1;
            n_s7_rem = 11'(w_rem_s7[11:0] - 12'(usc_pkg::DaysPerCycle));
        end else begin
            n_s7_cyc = r_s6_cyc;
            n_s7_rem = w_rem_s7[10:0];
        end
    end

    // stage 8: year within cycle, the last year keeps the extra day
    always_comb begin
        w_yoff = 2'(r_s7_rem >= usc_pkg::DaysPerYear)
               + 2'(r_s7_rem >= 11'(2 * 365))
               + 2'(r_s7_rem >= 11'(3 * 365));
        n_s8_doy  = 9'(r_s7_rem - 11'(w_yoff) * usc_pkg::DaysPerYear);
        n_s8_year = usc_pkg::CycleBaseYear + 12'({r_s7_cyc, 2'b00}) + 12'(w_yoff);
    end

    // stage 9: month by parallel compares against month starts
    always_comb begin
        w_mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_s8_doy >= usc_pkg::month_start(4'(i))) begin
                w_mp = w_mp + 4'd1;
            end
        end
        n_s9_day = 5'(r_s8_doy - usc_pkg::month_start(w_mp) + 9'd1);
        if (w_mp >= usc_pkg::MarchBasedJan) begin
            n_s9_month = w_mp - 4'd9;
            n_s9_year  = r_s8_year + 12'd1;
        end else begin
            n_s9_month = w_mp + 4'd3;
            n_s9_year  = r_s8_year;
        end
    end

    // stage registers, each loads when its stage moves
    always_ff @(posedge i_clk) begin
        if (i_stage_en[6]) begin
            r_s6_dp   <= n_s6_dp;
            r_s6_cyc  <= n_s6_cyc;
            r_s6_time <= {i_tod.hour, i_tod.minute, i_tod.second};
        end
        if (i_stage_en[7]) begin
            r_s7_cyc  <= n_s7_cyc;
            r_s7_rem  <= n_s7_rem;
            r_s7_time <= r_s6_time;
        end
        if (i_stage_en[8]) begin
            r_s8_year <= n_s8_year;
            r_s8_doy  <= n_s8_doy;
            r_s8_time <= r_s7_time;
        end
        if (i_stage_en[9]) begin
            r_s9_year  <= n_s9_year;
            r_s9_month <= n_s9_month;
            r_s9_day   <= n_s9_day;
            r_s9_time  <= r_s8_time;
        end
    end

    assign o_result.hour   = r_s9_time[16:12];
    assign o_result.minute = r_s9_time[11:6];
    assign o_result.second = r_s9_time[5:0];
    assign o_result.year   = r_s9_year;
    assign o_result.month  = r_s9_month;
    assign o_result.day    = r_s9_day;

endmodule

>>> rtl/unix_seconds_to_calendar.sv
// unix_seconds_to_calendar: ten-stage pipeline, seconds since 1970 to calendar
// path: an accepted beat moves through the stage 0 to stage 9 registers in order and is taken from stage 9
// throughput: one beat per cycle while the result sink keeps ready high; the datapath has ten register stages
// a stage with no valid beat fills even while later stages stall
// synchronous active-low reset clears the stage valid bits only
// depends on usc_pkg, usc_if, usc_tod and usc_date
module unix_seconds_to_calendar (
    input  logic      i_clk,
    input  logic      i_rst_n,
    usc_in_if.sink    i_in,
    usc_out_if.source o_out
);

    usc_pkg::t_stage_vec r_valid;
    usc_pkg::t_stage_vec w_stage_en;
    usc_pkg::t_tod       w_tod;
    usc_pkg::t_result    w_result;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        w_stage_en[usc_pkg::LastStage] = !r_valid[usc_pkg::LastStage] || o_out.ready;
        for (int k = usc_pkg::LastStage - 1; k >= 0; k--) begin
            w_stage_en[k] = !r_valid[k] || w_stage_en[k + 1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_stage_en[0]) begin
                r_valid[0] <= i_in.valid;
            end
            for (int k = 1; k < usc_pkg::Stages; k++) begin
                if (w_stage_en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    usc_tod u_tod (
        .i_clk           (i_clk),
        .i_stage_en      (w_stage_en),
        .i_epoch_seconds (i_in.epoch_seconds),
        .o_tod           (w_tod)
    );

    usc_date u_date (
        .i_clk      (i_clk),
        .i_stage_en (w_stage_en),
        .i_tod      (w_tod),
        .o_result   (w_result)
    );

    // channel outputs
    assign i_in.ready             = w_stage_en[0];
    assign o_out.valid            = r_valid[usc_pkg::LastStage];
    assign o_out.second_of_minute = w_result.second;
    assign o_out.minute_of_hour   = w_result.minute;
    assign o_out.hour_of_day      = w_result.hour;
    assign o_out.calendar_year    = w_result.year;
    assign o_out.month_number     = w_result.month;
    assign o_out.day_of_month     = w_result.day;

endmodule

>>> rtl/usc_check.sv
// usc_check: port-level assertions for unix_seconds_to_calendar, bound to it
// depends on usc_pkg and the top level's ports
module usc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_second,
    input logic [5:0]  i_minute,
    input logic [4:0]  i_hour,
    input logic [11:0] i_year,
    input logic [3:0]  i_month,
    input logic [4:0]  i_day
);

    logic [3:0] r_inflight;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_in_valid && i_in_ready;
    assign w_out_beat = i_out_valid && i_out_ready;

    // beats taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 4'(w_in_beat) - 4'(w_out_beat);
        end
    end

    // no result without a beat in flight, and never more than the pipeline holds
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || r_inflight != 4'd0) && r_inflight <= 4'(usc_pkg::Stages))
        else $error("result shown with no beat in flight");

    // result fields stay inside calendar ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_second < 6'd60 && i_minute < 6'd60 && i_hour < 5'd24
                         && i_month >= 4'd1 && i_month <= 4'd12
                         && i_day >= 5'd1 && i_day <= 5'd31
                         && i_year >= 12'd1970 && i_year <= 12'd2106))
        else $error("calendar field out of range");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_second)
            && $stable(i_minute) && $stable(i_hour) && $stable(i_year)
            && $stable(i_month) && $stable(i_day)))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind unix_seconds_to_calendar usc_check u_usc_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_second    (o_out.second_of_minute),
    .i_minute    (o_out.minute_of_hour),
    .i_hour      (o_out.hour_of_day),
    .i_year      (o_out.calendar_year),
    .i_month     (o_out.month_number),
    .i_day       (o_out.day_of_month)
);

>>> sim/unix_seconds_to_calendar_checker.sv
// unix_seconds_to_calendar_checker: watches both channels, predicts calendar fields
// for every accepted seconds beat and compares them with the result beats
// depends on usc_pkg and usc_if
`timescale 1ns / 100ps

module unix_seconds_to_calendar_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    usc_in_if     i_seconds,
    usc_out_if    i_calendar,
    output int    o_error_count,
    output int    o_pending
);

    localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    usc_pkg::t_result expected_dates [$];
    int               errors = 0;

    assign o_error_count = errors;
    assign o_pending     = expected_dates.size();

    // gregorian leap rule with the century exceptions
    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // calendar fields for one seconds count
    function automatic usc_pkg::t_result calendar_of(input logic [31:0] secs);
        usc_pkg::t_result date;
        int unsigned      days;
        int unsigned      yr;
        int unsigned      mo;
        int unsigned      span;
        date.second = 6'(secs % 60);
        date.minute = 6'((secs / 60) % 60);
        date.hour   = 5'((secs / 3600) % 24);
        days = secs / 86400;
        yr = 1970;
        span = leap_year(yr) ? 366 : 365;
        while (days >= span) begin
            days -= span;
            yr++;
            span = leap_year(yr) ? 366 : 365;
        end
        // walk the months, last month takes whatever remains
        mo = 0;
        span = MonthDays[0];
        while (mo < 11 && days >= span) begin
            days -= span;
            mo++;
            span = MonthDays[mo] + ((mo == 1 && leap_year(yr)) ? 1 : 0);
        end
        date.year  = 12'(yr);
        date.month = 4'(mo + 1);
        date.day   = 5'(days + 1);
        return date;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // seconds beats in, calendar beats out
    always @(posedge i_clk) begin
        usc_pkg::t_result want;
        if (i_rst_n) begin
            if (i_seconds.valid && i_seconds.ready) begin
                expected_dates.push_back(calendar_of(i_seconds.epoch_seconds));
            end
            if (i_calendar.valid && i_calendar.ready) begin
                if (expected_dates.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, got %0d-%0d-%0d",
                             $time, i_calendar.calendar_year, i_calendar.month_number,
                             i_calendar.day_of_month);
                end else begin
                    want = expected_dates.pop_front();
                    check_field("second_of_minute", want.second, i_calendar.second_of_minute);
                    check_field("minute_of_hour", want.minute, i_calendar.minute_of_hour);
                    check_field("hour_of_day", want.hour, i_calendar.hour_of_day);
                    check_field("calendar_year", want.year, i_calendar.calendar_year);
                    check_field("month_number", want.month, i_calendar.month_number);
                    check_field("day_of_month", want.day, i_calendar.day_of_month);
                end
            end
        end
    end

endmodule

>>> sim/unix_seconds_to_calendar_tb.sv
// unix_seconds_to_calendar_tb: clock, reset, seconds stimulus and result back-pressure
// for the seconds-to-calendar pipeline; checking lives in the checker module
// depends on usc_pkg, usc_if, unix_seconds_to_calendar and its checker
`timescale 1ns / 100ps

module unix_seconds_to_calendar_tb;

    localparam int RandomBeats  = 680;
    localparam int LongStall    = 100;
    localparam int SettleCycles = 20;
    localparam int NumEdges     = 22;

    // day, month, year and range boundaries
    localparam logic [31:0] EdgeSeconds [NumEdges] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd31535999,   32'd31536000,   32'd68169600,   32'd68256000,
        32'd951782400,  32'd951868800,  32'd978307199,  32'h7FFFFFFF,
        32'h80000000,   32'd4102444799, 32'd4107542399, 32'd4107542400,
        32'hFFFFFFFE,   32'hFFFFFFFF
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   error_count;
    int   pending;
    bit   long_stall_req  = 1'b0;
    bit   long_stall_done = 1'b0;

    usc_in_if  in_ch ();
    usc_out_if out_ch ();

    unix_seconds_to_calendar i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    unix_seconds_to_calendar_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seconds     (in_ch),
        .i_calendar    (out_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always #10 i_clk = ~i_clk;

    // hold valid and data until the beat is taken
    task automatic send_seconds(input logic [31:0] secs);
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= secs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly full range, some near midnight, 2100 and the top of the range
    function automatic logic [31:0] pick_seconds();
        logic [31:0] secs;
        case ($urandom_range(0, 9))
            6, 7:    secs = $urandom_range(0, 49710) * 32'd86400 - 32'd2 + $urandom_range(0, 4);
            8:       secs = $urandom_range(32'd4102444800 - 32'd34560000,
                                           32'd4102444800 + 32'd34560000);
            9:       secs = 32'hFFFFFFFF - $urandom_range(0, 200000);
            default: secs = $urandom;
        endcase
        return secs;
    endfunction

    // seconds source
    initial begin
        int burst_left;
        int gap;
        in_ch.valid         <= 1'b0;
        in_ch.epoch_seconds <= '0;
        i_rst_n             <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed boundaries, back to back
        foreach (EdgeSeconds[k]) send_seconds(EdgeSeconds[k]);
        send_seconds(32'hAAAAAAAA);
        send_seconds(32'h55555555);
        wait_drained();

        burst_left = 0;
        for (int n = 0; n < RandomBeats; n++) begin
            if (n == 200) begin
                // dense run while the sink holds off, fills the pipeline
                long_stall_req = 1'b1;
                for (int k = 0; k < 40; k++) send_seconds(pick_seconds());
                burst_left = 0;
            end
            if (n == 400) wait_drained();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            send_seconds(pick_seconds());
            burst_left--;
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result sink, stall patterns plus one long hold-off
    initial begin
        int mode;
        int seg;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(5, 60);
            for (int k = 0; k < seg; k++) begin
                if (long_stall_req && !long_stall_done) begin
                    out_ch.ready <= 1'b0;
                    repeat (LongStall) @(posedge i_clk);
                    long_stall_done = 1'b1;
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= $urandom_range(0, 1);
                    2:       out_ch.ready <= (k % 3 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // run limit
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
